// ----- hdl/swm_pkg.sv -----
package swm_pkg;

    localparam int SAMPLE_BITS  = 32;
    localparam int MAX_WINDOW   = 64;
    localparam int WIN_BITS     = 7;
    localparam int WINDOW_RESET = 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [WIN_BITS-1:0]           t_win;

    // one queue entry: value and its age in accepted samples
    typedef struct packed {
        logic    valid;
        t_sample value;
        t_win    age;
    } t_entry;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic    accept;
        logic    start;
        logic    shift;
        t_sample key;
    } t_cell_ctrl;

endpackage

// ----- hdl/swm_in_if.sv -----
interface swm_in_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink (input valid, input sample, input start_req, output ready);

endinterface

// ----- hdl/swm_out_if.sv -----
interface swm_out_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample window_min;

    modport source (output valid, output window_min, input ready);
    modport sink (input valid, input window_min, output ready);

endinterface

// ----- hdl/swm_cell.sv -----
module swm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swm_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_left_keep,
    input  swm_pkg::t_entry     i_right_post,
    output logic                o_keep,
    output swm_pkg::t_entry     o_post
);
    import swm_pkg::*;

    logic    r_valid;
    t_sample r_value;
    t_win    r_age;
    t_entry  n_entry;

    // entry survives the tail discard when valid, strictly below the new sample and no restart
    assign o_keep = r_valid && (r_value < i_ctrl.key) && !i_ctrl.start;

    // queue content at this slot once the new sample is appended
    always_comb begin
        o_post = '{valid: r_valid, value: r_value, age: r_age};
        if (i_ctrl.accept) begin
            if (o_keep) begin
                o_post = '{valid: 1'b1, value: r_value, age: r_age + t_win'(1)};
            end else begin
                o_post = '{valid: i_left_keep, value: i_ctrl.key, age: '0};
            end
        end
    end

    assign n_entry = i_ctrl.shift ? i_right_post : o_post;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_value <= n_entry.value;
        r_age   <= n_entry.age;
    end

endmodule

// ----- hdl/swm_ctrl.sv -----
module swm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  swm_pkg::t_win       i_cfg_data,
    input  logic                i_in_valid,
    input  swm_pkg::t_sample    i_sample,
    input  logic                i_start_req,
    output logic                o_in_ready,
    input  swm_pkg::t_entry     i_head,
    output swm_pkg::t_cell_ctrl o_cell_ctrl,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output swm_pkg::t_sample    o_out_data
);
    import swm_pkg::*;

    typedef enum logic {S_RUN, S_DRAIN} t_state;

    t_state  r_state, n_state;
    t_win    r_window;
    t_win    r_seen, n_seen;
    logic    r_out_valid, n_out_valid;
    t_sample r_out_data, n_out_data;

    t_win    w_eff;
    t_win    w_seen_base;
    t_win    w_seen_acc;
    logic    w_accept;
    logic    w_active;
    logic    w_stale;
    logic    w_want_out;
    logic    w_blocked;
    logic    w_shift;

    always_comb begin
        if (r_window == '0) begin
            w_eff = t_win'(1);
        end else if (r_window > t_win'(MAX_WINDOW)) begin
            w_eff = t_win'(MAX_WINDOW);
        end else begin
            w_eff = r_window;
        end
    end

    assign w_blocked   = r_out_valid && !i_out_ready;
    assign o_in_ready  = (r_state == S_RUN) && !w_blocked;
    assign w_accept    = o_in_ready && i_in_valid;
    assign w_active    = w_accept || (r_state == S_DRAIN);

    assign w_seen_base = i_start_req ? '0 : r_seen;
    assign w_seen_acc  = (w_seen_base < w_eff) ? w_seen_base + t_win'(1) : w_seen_base;

    // head older than the window must go before the minimum is read
    assign w_stale     = i_head.valid && (i_head.age >= w_eff);
    assign w_want_out  = (w_accept ? w_seen_acc : r_seen) >= w_eff;

    always_comb begin
        n_state     = r_state;
        n_seen      = w_accept ? w_seen_acc : r_seen;
        n_out_valid = w_blocked;
        n_out_data  = r_out_data;
        w_shift     = 1'b0;
        if (w_active) begin
            if (w_stale) begin
                w_shift = 1'b1;
                n_state = S_DRAIN;
            end else if ((r_state == S_DRAIN) && w_want_out && w_blocked) begin
                n_state = S_DRAIN;
            end else begin
                n_state = S_RUN;
                if (w_want_out) begin
                    n_out_valid = 1'b1;
                    n_out_data  = i_head.value;
                    // head leaves the window with the next sample
                    w_shift     = (i_head.age == w_eff - t_win'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_window    <= t_win'(WINDOW_RESET);
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
        end
        r_out_data <= n_out_data;
    end

    assign o_cell_ctrl = '{accept: w_accept, start: i_start_req, shift: w_shift, key: i_sample};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_drain_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> i_head.valid)
        else $error("drain with empty queue");

    a_shift_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> i_head.valid)
        else $error("head dropped from empty queue");

    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= t_win'(MAX_WINDOW))
        else $error("sample count past saturation");

endmodule

// ----- hdl/sliding_window_minimum.sv -----
// Sliding-window minimum over a stream of signed samples. Each input transaction
// carries one sample and a start flag that restarts the history with that sample.
// Once window_size samples have been taken since the last restart, every
// transaction yields one result: the minimum of the last window_size samples.
// The candidate minima sit in a row of 64 cells, head first; the tail discard
// and the append happen in the cycle the sample is taken, so the block takes
// one sample per clock while the window length stays put. Stale head entries
// are retired one per cycle through the cell chain: after the window is made
// shorter, the next sample holds the input until its stale entries (at most 63)
// are retired. The result is loaded into a one-deep output register when its
// sample is taken, or after a shrink when the stale entries are gone and the
// register is free; apart from draining, input is held only while that register
// is full and not being taken. Write window_size only while the block is idle;
// 0 acts as 1 and values above 64 act as 64.
module sliding_window_minimum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  swm_pkg::t_win  i_cfg_data,
    swm_in_if.sink         i_in,
    swm_out_if.source      o_out
);
    import swm_pkg::*;

    t_cell_ctrl w_ctrl;
    t_entry     w_post [0:MAX_WINDOW];
    logic       w_keep [0:MAX_WINDOW-1];

    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in.valid),
        .i_sample    (i_in.sample),
        .i_start_req (i_in.start_req),
        .o_in_ready  (i_in.ready),
        .i_head      (w_post[0]),
        .o_cell_ctrl (w_ctrl),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.window_min)
    );

    for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
        logic w_left_keep;
        if (j == 0) begin : g_head
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left_keep = w_keep[j-1];
        end
        swm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_left_keep  (w_left_keep),
            .i_right_post (w_post[j+1]),
            .o_keep       (w_keep[j]),
            .o_post       (w_post[j])
        );
    end

    // slot past the last cell: new sample when every stored entry survives
    assign w_post[MAX_WINDOW] = '{
        valid: w_ctrl.accept && w_keep[MAX_WINDOW-1],
        value: w_ctrl.key,
        age:   '0
    };

    a_head_after_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.accept |-> w_post[0].valid)
        else $error("queue empty after append");

    a_packed_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_ctrl.accept && w_post[1].valid) |-> w_post[0].valid)
        else $error("gap at queue head");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.window_min)))
        else $error("result changed while waiting");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import swm_pkg::*;

    localparam t_sample S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_sample S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    // idle time after the last expected result before touching the window
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_PHASES    = 11;

    typedef enum int {PAT_NOISE, PAT_NARROW, PAT_RISE, PAT_FALL, PAT_CORNER} t_pattern;

    // running model of the monotonic candidate queue
    class window_min_tracker;
        t_sample     cand_value [MAX_WINDOW];
        t_win        cand_pos [MAX_WINDOW];
        int unsigned cand_count;
        t_win        next_pos;
        int unsigned seen_count;
        t_win        win_reg;
        t_sample     expected_minima [$];
        int unsigned errors;
        int unsigned samples;
        int unsigned checked;
        int unsigned restarts;

        function new();
            win_reg    = t_win'(WINDOW_RESET);
            cand_count = 0;
            next_pos   = '0;
            seen_count = 0;
            errors     = 0;
            samples    = 0;
            checked    = 0;
            restarts   = 0;
        endfunction

        function void set_window(input t_win v);
            win_reg = v;
        endfunction

        function int unsigned span();
            if (win_reg == 0) return 1;
            if (win_reg > MAX_WINDOW) return MAX_WINDOW;
            return win_reg;
        endfunction

        // positions wrap at 2*MAX_WINDOW, which is exactly the range of t_win
        function t_win head_age();
            return t_win'(next_pos - cand_pos[0]);
        endfunction

        function void drop_head();
            if (cand_count == 0) return;
            for (int k = 1; k < cand_count; k++) begin
                cand_value[k-1] = cand_value[k];
                cand_pos[k-1]   = cand_pos[k];
            end
            cand_count--;
        endfunction

        function void take_sample(input t_sample s, input logic st);
            int unsigned w;
            w = span();
            samples++;
            if (st) begin
                cand_count = 0;
                next_pos   = '0;
                seen_count = 0;
                restarts++;
            end
            while (cand_count > 0 && cand_value[cand_count-1] >= s) cand_count--;
            if (cand_count >= MAX_WINDOW) drop_head();
            cand_value[cand_count] = s;
            cand_pos[cand_count]   = next_pos;
            cand_count++;
            // window may have shrunk since the head was queued
            while (cand_count > 0 && head_age() >= w) drop_head();
            if (seen_count < w) seen_count++;
            if (seen_count >= w && cand_count > 0) begin
                expected_minima = {expected_minima, cand_value[0]};
                if (head_age() == w - 1) drop_head();
            end
            next_pos++;
        endfunction

        function void check_min(input t_sample act);
            t_sample want;
            if (expected_minima.size() == 0) begin
                errors++;
                $error("window_min: expected none, actual %0d", act);
                return;
            end
            want = expected_minima[0];
            expected_minima.delete(0);
            checked++;
            if (act !== want) begin
                errors++;
                $error("window_min mismatch: expected %0d, actual %0d", want, act);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_win cfg_data;

    swm_in_if  in_ch ();
    swm_out_if out_ch ();

    window_min_tracker tracker = new();

    bit          gaps_on = 1'b1;
    int unsigned hold_off_cycles = 0;
    int unsigned settings_used = 1;
    t_sample     corner_vals [5] = '{S_MIN, S_MAX, 0, -1, 1};

    sliding_window_minimum dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // input transactions are noted before results are checked
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                tracker.take_sample(in_ch.sample, in_ch.start_req);
            if (out_ch.valid && out_ch.ready)
                tracker.check_min(out_ch.window_min);
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_off_cycles > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
                out_ch.ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 11) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_sample(input t_sample s, input logic st);
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= s;
        in_ch.start_req <= st;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (tracker.expected_minima.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input t_win v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.set_window(v);
        settings_used++;
    endtask

    task automatic run_random(input int unsigned count);
        t_pattern    pat;
        int unsigned run_left;
        int unsigned gap_pct;
        t_sample     s;
        logic        st;
        pat      = PAT_NOISE;
        run_left = 0;
        gap_pct  = 0;
        s        = '0;
        for (int unsigned i = 0; i < count; i++) begin
            if (run_left == 0) begin
                pat      = t_pattern'($urandom_range(0, 4));
                run_left = $urandom_range(4, 90);
                gap_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            run_left--;
            case (pat)
                PAT_NOISE:  s = t_sample'($urandom());
                PAT_NARROW: s = t_sample'(int'($urandom_range(0, 8)) - 4);
                PAT_RISE:   s = s + t_sample'($urandom_range(0, 3));
                PAT_FALL:   s = s - t_sample'($urandom_range(0, 3));
                default:    s = corner_vals[$urandom_range(0, 4)];
            endcase
            // restarts rare enough that long windows still warm up
            st = ($urandom_range(0, 3 * tracker.span() + 30) == 0);
            if (gaps_on && $urandom_range(1, 100) <= gap_pct) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            send_sample(s, st);
        end
    endtask

    initial begin
        t_win plan [NUM_PHASES];
        in_ch.valid     = 1'b0;
        in_ch.sample    = '0;
        in_ch.start_req = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, window of three from reset
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(0, 1'b1);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(4, 1'b0);
        send_sample(7, 1'b0);
        // single-sample window, restart on the first one
        write_window(t_win'(1));
        send_sample(100, 1'b1);
        send_sample(-100, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b1);

        plan = '{t_win'(0), t_win'(2), t_win'(64), t_win'(127), t_win'(65), t_win'(5),
                 t_win'($urandom_range(1, 64)), t_win'(33), t_win'($urandom_range(1, 64)),
                 t_win'(1), t_win'(3)};
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_window(plan[p]);
            if (p == NUM_PHASES - 1) gaps_on = 1'b0;
            // stall the result side long enough to back up the input
            if (p == 1) hold_off_cycles = 400;
            run_random(PHASE_ITEMS);
        end

        wait_drained();
        if (tracker.expected_minima.size() != 0) begin
            tracker.errors++;
            $error("window_min: %0d results never arrived", tracker.expected_minima.size());
        end
        $display("%0d samples sent with %0d restarts, %0d minima checked, %0d window settings",
                 tracker.samples, tracker.restarts, tracker.checked, settings_used);
        $display("windows included 0, 1, 64 and out-of-range 65 and 127, plus a long output stall");
        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
